// ===== sv/hspseq_pkg.sv =====
package hspseq_pkg;

	localparam int ADDR_W = 4;

	// register map, word index taken from paddr[3:2]
	localparam logic [1:0] REG_POWER_UP   = 2'd0;
	localparam logic [1:0] REG_CALIB      = 2'd1;
	localparam logic [1:0] REG_CONVERSION = 2'd2;
	localparam logic [1:0] REG_BUSY_RETRY = 2'd3;

	localparam logic [15:0] POWER_UP_RST   = 16'd40;
	localparam logic [15:0] CALIB_RST      = 16'd10;
	localparam logic [15:0] CONVERSION_RST = 16'd80;
	localparam logic [15:0] BUSY_RETRY_RST = 16'd10;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUSY     = 2'd1;
	localparam logic [1:0] ST_COMFAIL  = 2'd2;
	localparam logic [1:0] ST_INITFAIL = 2'd3;

	localparam logic [1:0] RK_NONE   = 2'd0;
	localparam logic [1:0] RK_STATUS = 2'd1;
	localparam logic [1:0] RK_DATA   = 2'd2;

	localparam logic [1:0] WK_NONE    = 2'd0;
	localparam logic [1:0] WK_CALIB   = 2'd1;
	localparam logic [1:0] WK_TRIGGER = 2'd2;

	// status byte bits
	localparam int BUSY_BIT  = 7;
	localparam int CALIB_BIT = 3;

	localparam int HUM_SCALE   = 1000;
	localparam int TEMP_SCALE  = 2000;
	localparam int TEMP_OFFSET = 500;

	typedef struct packed {
		logic [15:0] power_up_delay_ms;
		logic [15:0] calib_delay_ms;
		logic [15:0] conversion_delay_ms;
		logic [15:0] busy_retry_ms;
	} cfg_t;

	// one classified poll, waiting for decode
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  read_kind;
		logic [1:0]  write_kind;
		logic [19:0] raw_hum;
		logic [19:0] raw_temp;
	} item_t;

endpackage

// ===== sv/hspseq_front.sv =====
module hspseq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  hspseq_pkg::cfg_t   cfg,
	input  logic               accept,
	input  logic [31:0]        now_ms,
	input  logic               read_ok,
	input  logic               write_ok,
	input  logic [7:0]         rx_byte0,
	input  logic [7:0]         rx_byte1,
	input  logic [7:0]         rx_byte2,
	input  logic [7:0]         rx_byte3,
	input  logic [7:0]         rx_byte4,
	input  logic [7:0]         rx_byte5,
	output hspseq_pkg::item_t  item
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_POWER = 3'd1;
	localparam logic [2:0] PH_CALIB = 3'd2;
	localparam logic [2:0] PH_READY = 3'd3;
	localparam logic [2:0] PH_CONV  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic        pending_q, pending_d;
	logic        init_q, init_d;
	logic [31:0] deadline_q, deadline_d;

	logic [31:0] since;
	logic        passed;
	logic [1:0]  rdy;
	logic [1:0]  st;
	logic [1:0]  rk;
	logic [1:0]  wk;
	logic        upd_dl;
	logic [15:0] dly;

	assign since  = now_ms - deadline_q;
	assign passed = ~since[31];

	always_comb begin
		phase_d   = phase_q;
		pending_d = pending_q;
		init_d    = init_q;
		rdy       = hspseq_pkg::ST_BUSY;
		st        = hspseq_pkg::ST_BUSY;
		rk        = hspseq_pkg::RK_NONE;
		wk        = hspseq_pkg::WK_NONE;
		upd_dl    = 1'b0;
		dly       = '0;

		// power-up / calibration bring-up
		if (init_q && phase_q == PH_READY) begin
			rdy = hspseq_pkg::ST_OK;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = PH_POWER;
					upd_dl  = 1'b1;
					dly     = cfg.power_up_delay_ms;
				end
				PH_POWER: begin
					if (passed) begin
						rk = hspseq_pkg::RK_STATUS;
						if (!read_ok) begin
							phase_d = PH_IDLE;
							init_d  = 1'b0;
							rdy     = hspseq_pkg::ST_INITFAIL;
						end else if (!rx_byte0[hspseq_pkg::CALIB_BIT]) begin
							wk = hspseq_pkg::WK_CALIB;
							if (!write_ok) begin
								phase_d = PH_IDLE;
								init_d  = 1'b0;
								rdy     = hspseq_pkg::ST_INITFAIL;
							end else begin
								phase_d = PH_CALIB;
								upd_dl  = 1'b1;
								dly     = cfg.calib_delay_ms;
							end
						end else begin
							phase_d = PH_READY;
							init_d  = 1'b1;
							rdy     = hspseq_pkg::ST_OK;
						end
					end
				end
				PH_CALIB: begin
					if (passed) begin
						phase_d = PH_READY;
						init_d  = 1'b1;
						rdy     = hspseq_pkg::ST_OK;
					end
				end
				PH_READY: rdy = hspseq_pkg::ST_OK;
				default:  rdy = hspseq_pkg::ST_BUSY;
			endcase
		end

		// measurement: trigger, then data read once the conversion deadline passes
		if (rdy == hspseq_pkg::ST_INITFAIL) begin
			st = rdy;
		end else if (rdy == hspseq_pkg::ST_OK && !pending_q && phase_d == PH_READY) begin
			wk = hspseq_pkg::WK_TRIGGER;
			if (!write_ok) begin
				init_d  = 1'b0;
				phase_d = PH_IDLE;
				st      = hspseq_pkg::ST_COMFAIL;
			end else begin
				upd_dl    = 1'b1;
				dly       = cfg.conversion_delay_ms;
				pending_d = 1'b1;
				phase_d   = PH_CONV;
			end
		end else if (!pending_q || phase_d != PH_CONV || !passed) begin
			st = hspseq_pkg::ST_BUSY;
		end else begin
			rk = hspseq_pkg::RK_DATA;
			if (!read_ok) begin
				init_d    = 1'b0;
				pending_d = 1'b0;
				phase_d   = PH_IDLE;
				st        = hspseq_pkg::ST_COMFAIL;
			end else if (rx_byte0[hspseq_pkg::BUSY_BIT]) begin
				upd_dl = 1'b1;
				dly    = cfg.busy_retry_ms;
			end else begin
				pending_d = 1'b0;
				phase_d   = PH_READY;
				init_d    = 1'b1;
				st        = hspseq_pkg::ST_OK;
			end
		end

		deadline_d = upd_dl ? now_ms + {16'd0, dly} : deadline_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pending_q  <= 1'b0;
			init_q     <= 1'b0;
			deadline_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			init_q     <= init_d;
			deadline_q <= deadline_d;
		end
	end

	always_comb begin
		item.status     = st;
		item.read_kind  = rk;
		item.write_kind = wk;
		item.raw_hum    = {rx_byte1, rx_byte2, rx_byte3[7:4]};
		item.raw_temp   = {rx_byte3[3:0], rx_byte4, rx_byte5};
	end

	a_pending_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == (phase_q == PH_CONV))
		else $error("conversion pending out of step with phase");

	a_ready_is_init: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READY |-> init_q)
		else $error("ready phase without initialized flag");

	a_trigger_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.write_kind == hspseq_pkg::WK_TRIGGER
		|=> phase_q == PH_CONV || phase_q == PH_IDLE)
		else $error("trigger beat left an unexpected phase");

endmodule

// ===== sv/hspseq_fifo.sv =====
module hspseq_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hspseq_pkg::item_t  push_item,
	input  logic               pop,
	output hspseq_pkg::item_t  head_item,
	output logic               not_empty,
	output logic               full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hspseq_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wr_nxt, rd_nxt;

	assign wr_nxt = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign rd_nxt = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);

	assign head_item = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_nxt;
			end
			if (pop) begin
				rd_ptr_q <= rd_nxt;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");

endmodule

// ===== sv/hspseq_back.sv =====
module hspseq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hspseq_pkg::item_t  head_item,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [1:0]         read_kind,
	output logic [1:0]         write_kind,
	output logic signed [11:0] temperature,
	output logic [9:0]         humidity
);

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [1:0]  read_kind_q;
	logic [1:0]  write_kind_q;
	logic [11:0] temp_q;
	logic [9:0]  hum_q;

	logic [29:0] hum_prod;
	logic [30:0] temp_prod;
	logic [11:0] temp_c;
	logic        ok;

	assign pop = head_valid && (!out_valid_q || out_ready);
	assign ok  = head_item.status == hspseq_pkg::ST_OK;

	// raw * scale / 2^20
	assign hum_prod  = 30'(head_item.raw_hum) * 30'(hspseq_pkg::HUM_SCALE);
	assign temp_prod = 31'(head_item.raw_temp) * 31'(hspseq_pkg::TEMP_SCALE);
	assign temp_c    = {1'b0, temp_prod[30:20]} - 12'(hspseq_pkg::TEMP_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q     <= head_item.status;
			read_kind_q  <= head_item.read_kind;
			write_kind_q <= head_item.write_kind;
			temp_q       <= ok ? temp_c : '0;
			hum_q        <= ok ? hum_prod[29:20] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_kind   = read_kind_q;
	assign write_kind  = write_kind_q;
	assign temperature = $signed(temp_q);
	assign humidity    = hum_q;

	a_no_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != hspseq_pkg::ST_OK |-> temperature == '0 && humidity == '0)
		else $error("sample fields set on a beat without a new sample");

endmodule

// ===== sv/humidity_sensor_poll_sequencer_core.sv =====
// Poll sequencer for an I2C humidity/temperature sensor.
// Input channel (in_valid/in_ready): one beat per poll, carrying the millisecond
// timestamp and the bus answers (read_ok, write_ok, rx_byte0..5) for this poll.
// Output channel (out_valid/out_ready): exactly one beat per poll with status,
// the bus read/write done, and the decoded temperature/humidity in tenths.
// Configuration: APB write/read of four 16-bit delay registers at 0x0..0xC;
// pready is tied high, writes land on the access cycle.
// Path: input beat -> queue entry -> output register. Throughput: one poll per
// cycle while in_ready is high; the sequencer state updates on each accepted beat,
// and the constant-scale decode sits in the output stage behind a short queue.
// Receiver stall: the queue (QUEUE_DEPTH entries) plus the output register
// absorb QUEUE_DEPTH + 1 beats, then in_ready drops until out_ready returns.
// Reset: sequencer goes to idle, not initialized, no conversion pending,
// deadline 0; delay registers return to 40/10/80/10 ms; queue and output empty.
module humidity_sensor_poll_sequencer_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hspseq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   now_ms,
	input  logic                          read_ok,
	input  logic                          write_ok,
	input  logic [7:0]                    rx_byte0,
	input  logic [7:0]                    rx_byte1,
	input  logic [7:0]                    rx_byte2,
	input  logic [7:0]                    rx_byte3,
	input  logic [7:0]                    rx_byte4,
	input  logic [7:0]                    rx_byte5,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [1:0]                    read_kind,
	output logic [1:0]                    write_kind,
	output logic signed [11:0]            temperature,
	output logic [9:0]                    humidity
);

	hspseq_pkg::cfg_t  cfg_q;
	hspseq_pkg::item_t front_item;
	hspseq_pkg::item_t head_item;
	logic              cfg_wr;
	logic [1:0]        reg_idx;
	logic              accept;
	logic              q_full;
	logic              q_not_empty;
	logic              q_pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_delay_ms   <= hspseq_pkg::POWER_UP_RST;
			cfg_q.calib_delay_ms      <= hspseq_pkg::CALIB_RST;
			cfg_q.conversion_delay_ms <= hspseq_pkg::CONVERSION_RST;
			cfg_q.busy_retry_ms       <= hspseq_pkg::BUSY_RETRY_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hspseq_pkg::REG_POWER_UP:   cfg_q.power_up_delay_ms   <= pwdata[15:0];
				hspseq_pkg::REG_CALIB:      cfg_q.calib_delay_ms      <= pwdata[15:0];
				hspseq_pkg::REG_CONVERSION: cfg_q.conversion_delay_ms <= pwdata[15:0];
				hspseq_pkg::REG_BUSY_RETRY: cfg_q.busy_retry_ms       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hspseq_pkg::REG_POWER_UP:   prdata = {16'd0, cfg_q.power_up_delay_ms};
			hspseq_pkg::REG_CALIB:      prdata = {16'd0, cfg_q.calib_delay_ms};
			hspseq_pkg::REG_CONVERSION: prdata = {16'd0, cfg_q.conversion_delay_ms};
			hspseq_pkg::REG_BUSY_RETRY: prdata = {16'd0, cfg_q.busy_retry_ms};
			default:                    prdata = '0;
		endcase
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	hspseq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.now_ms   (now_ms),
		.read_ok  (read_ok),
		.write_ok (write_ok),
		.rx_byte0 (rx_byte0),
		.rx_byte1 (rx_byte1),
		.rx_byte2 (rx_byte2),
		.rx_byte3 (rx_byte3),
		.rx_byte4 (rx_byte4),
		.rx_byte5 (rx_byte5),
		.item     (front_item)
	);

	hspseq_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.pop       (q_pop),
		.head_item (head_item),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	hspseq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_item   (head_item),
		.head_valid  (q_not_empty),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_kind   (read_kind),
		.write_kind  (write_kind),
		.temperature (temperature),
		.humidity    (humidity)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 4;

	typedef enum logic [2:0] {
		PH_IDLE, PH_POWER, PH_CALIB, PH_READY, PH_CONV
	} seq_phase_t;

	typedef struct packed {
		logic [31:0]     now;
		logic            rd_ok;
		logic            wr_ok;
		logic [5:0][7:0] rx;
	} poll_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  read_kind;
		logic [1:0]  write_kind;
		logic [11:0] temperature;
		logic [9:0]  humidity;
	} reading_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [hspseq_pkg::ADDR_W-1:0]  paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_ready;
	logic [31:0]                    now_ms;
	logic                           read_ok;
	logic                           write_ok;
	logic [7:0]                     rx_byte0;
	logic [7:0]                     rx_byte1;
	logic [7:0]                     rx_byte2;
	logic [7:0]                     rx_byte3;
	logic [7:0]                     rx_byte4;
	logic [7:0]                     rx_byte5;
	logic                           out_valid;
	logic                           out_ready;
	logic [1:0]                     status;
	logic [1:0]                     read_kind;
	logic [1:0]                     write_kind;
	logic signed [11:0]             temperature;
	logic [9:0]                     humidity;

	// sensor shadow state
	hspseq_pkg::cfg_t delay_cfg;
	seq_phase_t       seq_phase;
	logic             conv_pending;
	logic             sensor_init;
	logic [31:0]      seq_deadline;

	reading_t    pending_readings[$];
	reading_t    reading_want;
	logic [31:0] poll_clock;
	bit          no_gaps;
	int unsigned rx_hold_cycles;
	int unsigned polls_sent;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned status_seen[4];

	humidity_sensor_poll_sequencer_core DUT (.*);

	always #5 clk = ~clk;

	function automatic bit deadline_passed(logic [31:0] t);
		logic [31:0] diff;
		diff = t - seq_deadline;
		return !diff[31];
	endfunction

	// advances the shadow sequencer by one poll and returns the reading it produces
	function automatic reading_t predict_reading(poll_t p);
		reading_t    r;
		logic [1:0]  ready;
		logic [19:0] raw_h;
		logic [19:0] raw_t;
		logic [31:0] scaled;
		r = '0;
		r.status = hspseq_pkg::ST_BUSY;
		if (sensor_init && seq_phase == PH_READY) begin
			ready = hspseq_pkg::ST_OK;
		end else if (seq_phase == PH_IDLE) begin
			seq_phase = PH_POWER;
			seq_deadline = p.now + {16'd0, delay_cfg.power_up_delay_ms};
			ready = hspseq_pkg::ST_BUSY;
		end else if (seq_phase == PH_POWER) begin
			if (!deadline_passed(p.now)) begin
				ready = hspseq_pkg::ST_BUSY;
			end else begin
				r.read_kind = hspseq_pkg::RK_STATUS;
				if (!p.rd_ok) begin
					seq_phase = PH_IDLE;
					sensor_init = 1'b0;
					ready = hspseq_pkg::ST_INITFAIL;
				end else if (!p.rx[0][hspseq_pkg::CALIB_BIT]) begin
					r.write_kind = hspseq_pkg::WK_CALIB;
					if (!p.wr_ok) begin
						seq_phase = PH_IDLE;
						sensor_init = 1'b0;
						ready = hspseq_pkg::ST_INITFAIL;
					end else begin
						seq_phase = PH_CALIB;
						seq_deadline = p.now + {16'd0, delay_cfg.calib_delay_ms};
						ready = hspseq_pkg::ST_BUSY;
					end
				end else begin
					seq_phase = PH_READY;
					sensor_init = 1'b1;
					ready = hspseq_pkg::ST_OK;
				end
			end
		end else if (seq_phase == PH_CALIB) begin
			if (!deadline_passed(p.now)) begin
				ready = hspseq_pkg::ST_BUSY;
			end else begin
				seq_phase = PH_READY;
				sensor_init = 1'b1;
				ready = hspseq_pkg::ST_OK;
			end
		end else begin
			ready = (seq_phase == PH_READY) ? hspseq_pkg::ST_OK : hspseq_pkg::ST_BUSY;
		end

		if (ready != hspseq_pkg::ST_OK && ready != hspseq_pkg::ST_BUSY) begin
			r.status = ready;
		end else if (ready == hspseq_pkg::ST_OK && !conv_pending && seq_phase == PH_READY) begin
			r.write_kind = hspseq_pkg::WK_TRIGGER;
			if (!p.wr_ok) begin
				sensor_init = 1'b0;
				seq_phase = PH_IDLE;
				r.status = hspseq_pkg::ST_COMFAIL;
			end else begin
				seq_deadline = p.now + {16'd0, delay_cfg.conversion_delay_ms};
				conv_pending = 1'b1;
				seq_phase = PH_CONV;
				r.status = hspseq_pkg::ST_BUSY;
			end
		end else if (!conv_pending || seq_phase != PH_CONV || !deadline_passed(p.now)) begin
			r.status = hspseq_pkg::ST_BUSY;
		end else begin
			r.read_kind = hspseq_pkg::RK_DATA;
			if (!p.rd_ok) begin
				sensor_init = 1'b0;
				conv_pending = 1'b0;
				seq_phase = PH_IDLE;
				r.status = hspseq_pkg::ST_COMFAIL;
			end else if (p.rx[0][hspseq_pkg::BUSY_BIT]) begin
				seq_deadline = p.now + {16'd0, delay_cfg.busy_retry_ms};
				r.status = hspseq_pkg::ST_BUSY;
			end else begin
				raw_h = {p.rx[1], p.rx[2], p.rx[3][7:4]};
				raw_t = {p.rx[3][3:0], p.rx[4], p.rx[5]};
				scaled = {12'd0, raw_h} * 32'(hspseq_pkg::HUM_SCALE);
				r.humidity = scaled[29:20];
				scaled = {12'd0, raw_t} * 32'(hspseq_pkg::TEMP_SCALE);
				r.temperature = scaled[31:20] - 12'(hspseq_pkg::TEMP_OFFSET);
				conv_pending = 1'b0;
				seq_phase = PH_READY;
				sensor_init = 1'b1;
				r.status = hspseq_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	function automatic poll_t mk_poll(logic [31:0] t, bit rd, bit wr, logic [7:0] b0,
			logic [7:0] fill);
		poll_t p;
		p.now = t;
		p.rd_ok = rd;
		p.wr_ok = wr;
		p.rx = {{5{fill}}, b0};
		p.rx[0] = b0;
		return p;
	endfunction

	// well-formed polls move time forward, bus answers failing 1 in 30; noisy ones jump anywhere half the time
	function automatic poll_t next_poll(bit noisy);
		poll_t       p;
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (noisy && pick < 8)
			poll_clock = $urandom();
		else if (pick == 0)
			poll_clock += $urandom_range(0, 140000);
		else
			poll_clock += $urandom_range(0, 25);
		p.now = poll_clock;
		p.rd_ok = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) != 0);
		p.wr_ok = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) != 0);
		for (int i = 0; i < 6; i++)
			p.rx[i] = 8'($urandom_range(0, 255));
		if (!noisy)
			p.rx[0][hspseq_pkg::BUSY_BIT] = ($urandom_range(0, 3) == 0);
		return p;
	endfunction

	task automatic send_poll(poll_t p);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		now_ms = p.now;
		read_ok = p.rd_ok;
		write_ok = p.wr_ok;
		rx_byte0 = p.rx[0];
		rx_byte1 = p.rx[1];
		rx_byte2 = p.rx[2];
		rx_byte3 = p.rx[3];
		rx_byte4 = p.rx[4];
		rx_byte5 = p.rx[5];
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(predict_reading(p));
		polls_sent++;
	endtask

	task automatic run_polls(int unsigned n, bit noisy);
		repeat (n) send_poll(next_poll(noisy));
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_delay_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = hspseq_pkg::ADDR_W'({idx, 2'b00});
		pwdata = {16'($urandom()), val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			hspseq_pkg::REG_POWER_UP:   delay_cfg.power_up_delay_ms = val;
			hspseq_pkg::REG_CALIB:      delay_cfg.calib_delay_ms = val;
			hspseq_pkg::REG_CONVERSION: delay_cfg.conversion_delay_ms = val;
			hspseq_pkg::REG_BUSY_RETRY: delay_cfg.busy_retry_ms = val;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_delays(logic [15:0] pu, logic [15:0] cal, logic [15:0] conv,
			logic [15:0] retry);
		drain_pipeline();
		write_delay_reg(hspseq_pkg::REG_POWER_UP, pu);
		write_delay_reg(hspseq_pkg::REG_CALIB, cal);
		write_delay_reg(hspseq_pkg::REG_CONVERSION, conv);
		write_delay_reg(hspseq_pkg::REG_BUSY_RETRY, retry);
	endtask

	// reset delays: power-up, calibration, conversion, busy retry, data decode extremes, trigger write fail
	task automatic test_default_walk();
		send_poll(mk_poll(32'd0, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd39, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd40, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd49, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd50, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd129, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd130, 1, 1, 8'h80, 8'h00));
		send_poll(mk_poll(32'd140, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd141, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd221, 1, 1, 8'h7F, 8'hFF));
		send_poll(mk_poll(32'd222, 1, 0, 8'h00, 8'h00));
	endtask

	// status read fail, calibrate write fail, already calibrated, data read fail
	task automatic test_bus_failures();
		send_poll(mk_poll(32'd1000, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd1040, 0, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd1041, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd1081, 1, 0, 8'h00, 8'h00));
		send_poll(mk_poll(32'd1082, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'd1122, 1, 1, 8'h08, 8'h00));
		send_poll(mk_poll(32'd1202, 0, 1, 8'h00, 8'h55));
	endtask

	task automatic test_timestamp_wrap();
		send_poll(mk_poll(32'hFFFF_FFF0, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'hFFFF_FFFF, 1, 1, 8'h00, 8'h00));
		send_poll(mk_poll(32'h0000_0018, 1, 1, 8'h08, 8'h00));
		send_poll(mk_poll(32'h0000_0068, 1, 1, 8'h00, 8'hA5));
	endtask

	task automatic test_delay_settings();
		poll_clock = $urandom();
		set_delays(16'd0, 16'd0, 16'd0, 16'd0);
		run_polls(200, 0);
		set_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_polls(200, 0);
		set_delays(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
			16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)));
		run_polls(200, 0);
		set_delays(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
		run_polls(200, 0);
		set_delays(hspseq_pkg::POWER_UP_RST, hspseq_pkg::CALIB_RST,
			hspseq_pkg::CONVERSION_RST, hspseq_pkg::BUSY_RETRY_RST);
		run_polls(200, 0);
	endtask

	task automatic test_noise();
		run_polls(150, 1);
	endtask

	// receiver stalls long enough for the queue to fill and back up the input
	task automatic test_back_pressure();
		no_gaps = 1'b1;
		rx_hold_cycles = 300;
		run_polls(60, 0);
		no_gaps = 1'b0;
	endtask

	task automatic test_no_idle();
		no_gaps = 1'b1;
		run_polls(200, 0);
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		now_ms = '0;
		read_ok = 1'b0;
		write_ok = 1'b0;
		rx_byte0 = '0;
		rx_byte1 = '0;
		rx_byte2 = '0;
		rx_byte3 = '0;
		rx_byte4 = '0;
		rx_byte5 = '0;
		no_gaps = 1'b0;
		rx_hold_cycles = 0;
		polls_sent = 0;
		mismatches = 0;
		delay_cfg = {hspseq_pkg::POWER_UP_RST, hspseq_pkg::CALIB_RST,
			hspseq_pkg::CONVERSION_RST, hspseq_pkg::BUSY_RETRY_RST};
		seq_phase = PH_IDLE;
		conv_pending = 1'b0;
		sensor_init = 1'b0;
		seq_deadline = '0;
		poll_clock = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_default_walk();
		test_bus_failures();
		test_timestamp_wrap();
		test_delay_settings();
		test_noise();
		test_back_pressure();
		test_no_idle();

		drain_pipeline();
		mismatches += pending_readings.size();
		$display("Sent %0d polls: directed walk, bus failures, timestamp wrap, five delay settings,",
			polls_sent);
		$display("noise, back-pressure and gapless runs; %0d ok, %0d busy, %0d comm, %0d init fail.",
			status_seen[hspseq_pkg::ST_OK], status_seen[hspseq_pkg::ST_BUSY],
			status_seen[hspseq_pkg::ST_COMFAIL], status_seen[hspseq_pkg::ST_INITFAIL]);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// receiver: random stall per beat, or one long hold when a test asks for it
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 9);
			end
			@(negedge clk);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				$error("result beat with no poll outstanding");
				mismatches++;
			end else begin
				reading_want = pending_readings.pop_front();
				status_seen[status]++;
				if (status !== reading_want.status) begin
					$error("status: expected %0d, got %0d", reading_want.status, status);
					mismatches++;
				end
				if (read_kind !== reading_want.read_kind) begin
					$error("read_kind: expected %0d, got %0d", reading_want.read_kind, read_kind);
					mismatches++;
				end
				if (write_kind !== reading_want.write_kind) begin
					$error("write_kind: expected %0d, got %0d", reading_want.write_kind,
						write_kind);
					mismatches++;
				end
				if (temperature !== reading_want.temperature) begin
					$error("temperature: expected %0d, got %0d",
						$signed(reading_want.temperature), temperature);
					mismatches++;
				end
				if (humidity !== reading_want.humidity) begin
					$error("humidity: expected %0d, got %0d", reading_want.humidity, humidity);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
